>>> rtl/xasc_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the xml attribute span scanner
// no dependencies

package xasc_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;

    typedef enum logic [2:0] {
        MODE_SKIP_LT   = 3'd0,
        MODE_ELEM      = 3'd1,
        MODE_GAP       = 3'd2,
        MODE_NAME      = 3'd3,
        MODE_POST_NAME = 3'd4,
        MODE_AFTER_EQ  = 3'd5,
        MODE_QUOTED    = 3'd6,
        MODE_STOP      = 3'd7
    } t_scan_mode;

    typedef struct packed {
        logic [7:0]  text_byte;
        logic [31:0] tag_base;
        logic        tag_last;
    } t_in_item;

    typedef struct packed {
        logic [31:0] span_begin;
        logic [31:0] span_end;
        logic        run_last;
    } t_out_item;

    // results produced by one accepted byte
    typedef struct packed {
        logic [1:0] count;
        t_out_item  first;
        t_out_item  second;
    } t_scan_res;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic logic is_stop(input logic [7:0] c);
        return (c == CH_GT) || (c == CH_SLASH);
    endfunction

endpackage

>>> rtl/xasc_core.sv
`timescale 1ns / 1ps
// scan state machine: one tag byte per transfer, up to two spans out
// depends on xasc_pkg

module xasc_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_acc,
    input  xasc_pkg::t_in_item i_item,
    output xasc_pkg::t_scan_res o_res
);
    import xasc_pkg::*;

    t_scan_mode  r_mode, n_mode;
    logic [31:0] r_pos, n_pos;
    logic [31:0] r_name_start, n_name_start;
    logic [31:0] r_pend, n_pend;
    logic        r_qsingle, n_qsingle;

    logic [31:0] pos;
    logic [7:0]  c;
    logic        emit_a, emit_b;
    logic [31:0] a_end, b_end;
    logic [7:0]  close_q;

    always_comb begin
        c       = i_item.text_byte;
        pos     = (r_mode == MODE_SKIP_LT) ? i_item.tag_base : r_pos + 32'd1;
        close_q = r_qsingle ? CH_SQUOTE : CH_DQUOTE;

        n_mode       = r_mode;
        n_pos        = pos;
        n_name_start = r_name_start;
        n_pend       = r_pend;
        n_qsingle    = r_qsingle;
        emit_a       = 1'b0;
        a_end        = r_pend;
        emit_b       = 1'b0;
        b_end        = r_pend;

        unique case (r_mode)
            MODE_SKIP_LT: n_mode = MODE_ELEM;
            MODE_ELEM: begin
                if (is_ws(c)) n_mode = MODE_GAP;
                else if (is_stop(c)) n_mode = MODE_STOP;
            end
            MODE_GAP: begin
                if (!is_ws(c)) begin
                    if (is_stop(c)) begin
                        n_mode = MODE_STOP;
                    end else begin
                        n_name_start = pos;
                        if (c == CH_EQUAL) begin
                            n_pend = pos;
                            n_mode = MODE_AFTER_EQ;
                        end else begin
                            n_mode = MODE_NAME;
                        end
                    end
                end
            end
            MODE_NAME: begin
                if (is_ws(c)) begin
                    n_pend = pos;
                    n_mode = MODE_POST_NAME;
                end else if (c == CH_EQUAL) begin
                    n_pend = pos;
                    n_mode = MODE_AFTER_EQ;
                end else if (is_stop(c)) begin
                    n_pend = pos;
                    emit_a = 1'b1;
                    a_end  = pos;
                    n_mode = MODE_STOP;
                end
            end
            MODE_POST_NAME, MODE_AFTER_EQ: begin
                if ((r_mode == MODE_POST_NAME) && (c == CH_EQUAL)) begin
                    n_mode = MODE_AFTER_EQ;
                end else if ((r_mode == MODE_AFTER_EQ) &&
                             ((c == CH_SQUOTE) || (c == CH_DQUOTE))) begin
                    n_qsingle = (c == CH_SQUOTE);
                    n_mode    = MODE_QUOTED;
                end else if (!is_ws(c)) begin
                    // previous name closes, this byte may open the next one
                    emit_a = 1'b1;
                    a_end  = r_pend;
                    if (is_stop(c)) begin
                        n_mode = MODE_STOP;
                    end else begin
                        n_name_start = pos;
                        if (c == CH_EQUAL) begin
                            n_pend = pos;
                            n_mode = MODE_AFTER_EQ;
                        end else begin
                            n_mode = MODE_NAME;
                        end
                    end
                end
            end
            MODE_QUOTED: begin
                if (c == close_q) begin
                    emit_a = 1'b1;
                    a_end  = pos + 32'd1;
                    n_mode = MODE_GAP;
                end
            end
            MODE_STOP: ;
            default: ;
        endcase

        if (i_item.tag_last) begin
            case (n_mode)
                MODE_NAME, MODE_QUOTED: begin
                    emit_b = 1'b1;
                    b_end  = pos + 32'd1;
                end
                MODE_POST_NAME, MODE_AFTER_EQ: begin
                    emit_b = 1'b1;
                    b_end  = n_pend;
                end
                default: ;
            endcase
            n_mode = MODE_SKIP_LT;
        end

        // the stage-a span uses the name start seen before this byte
        o_res.count  = i_acc ? (2'(emit_a) + 2'(emit_b)) : 2'd0;
        o_res.first  = emit_a ? t_out_item'{span_begin: r_name_start, span_end: a_end,
                                            run_last: !emit_b}
                              : t_out_item'{span_begin: n_name_start, span_end: b_end,
                                            run_last: 1'b1};
        o_res.second = t_out_item'{span_begin: n_name_start, span_end: b_end,
                                   run_last: 1'b1};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_SKIP_LT;
            r_pos        <= '0;
            r_name_start <= '0;
            r_pend       <= '0;
            r_qsingle    <= 1'b0;
        end else if (i_acc) begin
            r_mode       <= n_mode;
            r_pos        <= n_pos;
            r_name_start <= n_name_start;
            r_pend       <= n_pend;
            r_qsingle    <= n_qsingle;
        end
    end

    a_last_rewinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_acc && i_item.tag_last |=> r_mode == MODE_SKIP_LT)
        else $error("tag end did not return scanner to start");

    a_two_needs_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.count == 2'd2 |-> i_item.tag_last && !o_res.first.run_last)
        else $error("two spans from a byte that is not a tag end");

    a_no_three: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.count != 2'd3)
        else $error("more than two spans from one byte");

endmodule

>>> rtl/xasc_queue.sv
`timescale 1ns / 1ps
// small result queue: takes up to two spans per cycle, gives one per transfer
// depends on xasc_pkg

module xasc_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  xasc_pkg::t_scan_res i_res,
    output logic                o_full,
    output logic                o_valid,
    input  logic                i_stall,
    output xasc_pkg::t_out_item o_item
);
    import xasc_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_out_item       r_mem [QUEUE_DEPTH];
    logic [PW-1:0]   r_wr, n_wr;
    logic [PW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_count, n_count;
    logic            pop;
    logic [PW-1:0]   wr_next;

    assign pop     = o_valid && !i_stall;
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];
    // room must exist for a worst-case pair
    assign o_full  = (r_count > CW'(QUEUE_DEPTH - 2));
    assign wr_next = r_wr + PW'(1);

    always_comb begin
        n_wr    = r_wr + PW'(i_res.count);
        n_rd    = pop ? r_rd + PW'(1) : r_rd;
        n_count = r_count + CW'(i_res.count) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_res.count != 2'd0) r_mem[r_wr] <= i_res.first;
        if (i_res.count == 2'd2) r_mem[wr_next] <= i_res.second;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) + int'(i_res.count) <= QUEUE_DEPTH)
        else $error("result queue overflow");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= QUEUE_DEPTH)
        else $error("result queue count out of range");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res.count == 2'd0 && pop |=> r_count == $past(r_count) - CW'(1))
        else $error("queue count did not drop on pop");

endmodule

>>> rtl/xml_attribute_span_scanner_top.sv
`timescale 1ns / 1ps
// top level of the xml attribute span scanner
// depends on xasc_pkg, xasc_core, xasc_queue
//
// output: with the queue empty, a span is offered the cycle after the byte transfer
//   that caused it; the second span of a pair is offered after the first
// throughput: one tag byte per cycle; output gives one span per cycle unless stalled;
//   the input stalls while three or more spans wait in the four-entry result queue
// reset: synchronous active low; scanner returns to skipping the opening bracket with
//   all positions zero and the result queue empty

module xml_attribute_span_scanner_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // tag byte channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  xasc_pkg::t_in_item  i_in_data,
    // span channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output xasc_pkg::t_out_item o_out_data
);
    import xasc_pkg::*;

    logic      in_xfer;   // a byte transfer happens this cycle
    t_scan_res scan_res;  // spans produced by the byte in transfer
    logic      q_full;

    // stall depends only on queue occupancy, never on the input valid
    assign o_in_stall = q_full;
    assign in_xfer    = i_in_valid && !q_full;

    // scan state lives in the core; it advances only on a transfer
    xasc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (in_xfer),
        .i_item  (i_in_data),
        .o_res   (scan_res)
    );

    // queue acts as the result register and decouples the two sides
    xasc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (scan_res),
        .o_full  (q_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out_data)
    );

endmodule

>>> dv/xml_attribute_span_scanner_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for xml_attribute_span_scanner_top: directed tags, then random tags
// depends on xasc_pkg and the scanner rtl; holds its own span predictor

module testbench;
    import xasc_pkg::*;

    // cycles with no transfer on either channel before the run is called hung
    localparam int WATCHDOG_LIMIT = 4000;
    // scanned (not ignored) tag bytes in the random part, split over the phases
    localparam int RANDOM_ITEMS   = 1350;
    // spans pass through the result queue after their byte; give the queue some slack
    localparam int DRAIN_CYCLES   = 8;
    localparam int NUM_PHASES     = 4;
    localparam int NUM_ROWS       = 28;
    localparam int MAX_PRINTS     = 30;

    localparam logic [7:0] CH_LT = 8'h3C;

    // one directed row: the byte, its base and last flag, and optionally hand-written spans
    typedef struct {
        logic [7:0]  c;
        logic [31:0] base;
        logic        last;
        logic        typed;
        int          cnt;
        logic [31:0] b0;
        logic [31:0] e0;
        logic [31:0] b1;
        logic [31:0] e1;
    } t_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    xml_attribute_span_scanner_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // span predictor: private copy of the scanner state
    // ------------------------------------------------------------------
    t_scan_mode  sc_mode     = MODE_SKIP_LT;
    logic [31:0] sc_pos      = '0;
    logic [31:0] sc_name_at  = '0;
    logic [31:0] sc_name_end = '0;
    logic        sc_single   = 1'b0;

    // spans caused by the byte just scanned
    int          got;
    t_out_item   got_span [2];

    // spans still owed by the dut, oldest first
    t_out_item   span_fifo [$];

    int err_count   = 0;
    int items_sent  = 0;
    int live_items  = 0;
    int spans_seen  = 0;
    int tags_sent   = 0;
    int quiet       = 0;
    int send_idle_pct  = 0;
    int stall_pct      = 0;

    // book one span the dut owes, behind the older ones
    function void owe_span(t_out_item s);
        span_fifo = {span_fifo, s};
    endfunction

    function automatic bit blank_char(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
    endfunction

    function automatic bit halt_char(logic [7:0] c);
        return c == CH_GT || c == CH_SLASH;
    endfunction

    // append a span; the previous one of this byte is no longer the last
    function void add_span(logic [31:0] b, logic [31:0] e);
        if (got > 0) got_span[got-1].run_last = 1'b0;
        got_span[got] = '{span_begin: b, span_end: e, run_last: 1'b1};
        got++;
    endfunction

    // non-blank byte where an attribute name may start
    function void open_name(logic [7:0] c, logic [31:0] at);
        if (halt_char(c)) begin
            sc_mode = MODE_STOP;
            return;
        end
        sc_name_at = at;
        if (c == CH_EQUAL) begin
            // empty name
            sc_name_end = at;
            sc_mode = MODE_AFTER_EQ;
        end else begin
            sc_mode = MODE_NAME;
        end
    endfunction

    function void scan_byte(t_in_item it);
        logic [7:0]  c;
        logic [31:0] at;
        c   = it.text_byte;
        got = 0;
        // base is only taken on the first byte of a tag
        at = (sc_mode == MODE_SKIP_LT) ? it.tag_base : sc_pos + 32'd1;
        sc_pos = at;
        case (sc_mode)
            MODE_SKIP_LT: sc_mode = MODE_ELEM;
            MODE_ELEM: begin
                if (blank_char(c)) sc_mode = MODE_GAP;
                else if (halt_char(c)) sc_mode = MODE_STOP;
            end
            MODE_GAP: begin
                if (!blank_char(c)) open_name(c, at);
            end
            MODE_NAME: begin
                if (blank_char(c)) begin
                    sc_name_end = at;
                    sc_mode = MODE_POST_NAME;
                end else if (c == CH_EQUAL) begin
                    sc_name_end = at;
                    sc_mode = MODE_AFTER_EQ;
                end else if (halt_char(c)) begin
                    // name cut short by a stop char is still reported
                    sc_name_end = at;
                    add_span(sc_name_at, sc_name_end);
                    sc_mode = MODE_STOP;
                end
            end
            MODE_POST_NAME: begin
                if (c == CH_EQUAL) begin
                    sc_mode = MODE_AFTER_EQ;
                end else if (!blank_char(c)) begin
                    add_span(sc_name_at, sc_name_end);
                    open_name(c, at);
                end
            end
            MODE_AFTER_EQ: begin
                if (c == CH_SQUOTE || c == CH_DQUOTE) begin
                    sc_single = (c == CH_SQUOTE);
                    sc_mode = MODE_QUOTED;
                end else if (!blank_char(c)) begin
                    // unquoted value: span ends at the name, char starts the next name
                    add_span(sc_name_at, sc_name_end);
                    open_name(c, at);
                end
            end
            MODE_QUOTED: begin
                if (c == (sc_single ? CH_SQUOTE : CH_DQUOTE)) begin
                    add_span(sc_name_at, at + 32'd1);
                    sc_mode = MODE_GAP;
                end
            end
            default: ;
        endcase
        if (it.tag_last) begin
            // flush whatever attribute is still open at the tag end
            case (sc_mode)
                MODE_NAME, MODE_QUOTED:        add_span(sc_name_at, at + 32'd1);
                MODE_POST_NAME, MODE_AFTER_EQ: add_span(sc_name_at, sc_name_end);
                default: ;
            endcase
            sc_mode = MODE_SKIP_LT;
        end
    endfunction

    // ------------------------------------------------------------------
    // random tag builder
    // ------------------------------------------------------------------
    t_in_item tag_bytes [$];

    function void put_byte(logic [7:0] c);
        t_in_item it;
        it.text_byte = c;
        // base on later bytes is ignored, so keep it random
        it.tag_base  = $urandom;
        it.tag_last  = 1'b0;
        tag_bytes = {tag_bytes, it};
    endfunction

    // mostly lower-case letters, sometimes any byte that cannot end a name
    function logic [7:0] name_char();
        logic [7:0] c;
        if ($urandom_range(9) < 7) return 8'h61 + 8'($urandom_range(25));
        do c = 8'($urandom_range(255));
        while (blank_char(c) || halt_char(c) || c == CH_EQUAL ||
               c == CH_SQUOTE || c == CH_DQUOTE);
        return c;
    endfunction

    function logic [7:0] value_char(logic [7:0] q);
        logic [7:0] c;
        if ($urandom_range(1)) return 8'h61 + 8'($urandom_range(25));
        do c = 8'($urandom_range(255)); while (c == q);
        return c;
    endfunction

    function logic [7:0] blank_pick();
        case ($urandom_range(3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    function void build_tag();
        int         kind;
        int         n;
        int         form;
        int         cut;
        logic [7:0] q;
        bit         open_quote;
        tag_bytes.delete();
        open_quote = 1'b0;
        kind = $urandom_range(99);
        if (kind < 12) begin
            // noise: arbitrary bytes
            n = $urandom_range(1, 10);
            repeat (n) put_byte(8'($urandom_range(255)));
        end else begin
            put_byte(($urandom_range(9) == 0) ? 8'($urandom_range(255)) : CH_LT);
            repeat ($urandom_range(0, 3)) put_byte(name_char());
            repeat ($urandom_range(0, 3)) begin
                if (!open_quote) begin
                    repeat ($urandom_range(1, 2)) put_byte(blank_pick());
                    n = $urandom_range(0, 4);
                    repeat (n) put_byte(name_char());
                    // 0..1 bare, 2..7 quoted, 8..9 unquoted
                    form = $urandom_range(9);
                    if (n == 0 && form < 2) form = 2;
                    if (form >= 2) begin
                        if ($urandom_range(3) == 0) put_byte(blank_pick());
                        put_byte(CH_EQUAL);
                        if ($urandom_range(3) == 0) put_byte(blank_pick());
                        if (form < 8) begin
                            q = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
                            put_byte(q);
                            repeat ($urandom_range(0, 5)) put_byte(value_char(q));
                            if ($urandom_range(11) == 0) open_quote = 1'b1;
                            else put_byte(q);
                        end else begin
                            repeat ($urandom_range(1, 3)) put_byte(name_char());
                        end
                    end
                end
            end
            if (!open_quote) begin
                if ($urandom_range(1)) put_byte(blank_pick());
                if ($urandom_range(9) < 3) put_byte(CH_SLASH);
                if ($urandom_range(9) < 9) put_byte(CH_GT);
                // junk after the stop is ignored by the scanner
                if ($urandom_range(9) == 0) begin
                    repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(255)));
                end
            end
            // broken tag: cut anywhere
            if ($urandom_range(9) == 0) begin
                cut = $urandom_range(1, tag_bytes.size());
                while (tag_bytes.size() > cut) void'(tag_bytes.pop_back());
            end
        end
        if ($urandom_range(7) == 0) tag_bytes[0].tag_base = 32'hFFFF_FFFF - $urandom_range(24);
        else tag_bytes[0].tag_base = $urandom;
        tag_bytes[tag_bytes.size()-1].tag_last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // mismatch reporting and span checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        if (err_count < MAX_PRINTS) $display("mismatch @%0t: %s", $realtime, what);
        err_count++;
    endtask

    t_out_item want;

    // every span transfer is matched against the oldest owed span
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            spans_seen++;
            if (span_fifo.size() == 0) begin
                report_mismatch($sformatf("unexpected span %h..%h",
                                          o_out_data.span_begin, o_out_data.span_end));
            end else begin
                want = span_fifo.pop_front();
                if (o_out_data.span_begin !== want.span_begin)
                    report_mismatch($sformatf("span_begin %h, want %h",
                                              o_out_data.span_begin, want.span_begin));
                if (o_out_data.span_end !== want.span_end)
                    report_mismatch($sformatf("span_end %h, want %h",
                                              o_out_data.span_end, want.span_end));
                if (o_out_data.run_last !== want.run_last)
                    report_mismatch($sformatf("run_last %b, want %b",
                                              o_out_data.run_last, want.run_last));
            end
        end
    end

    // receiver side: random stall, applied at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // watchdog: ends a run in which nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    // offer one byte, wait for its transfer, then book the spans it owes
    task automatic send_byte(input t_in_item it, input logic typed, input int cnt,
                             input logic [31:0] b0, input logic [31:0] e0,
                             input logic [31:0] b1, input logic [31:0] e1);
        bit was_live;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        // transfer happened at this edge
        was_live = (sc_mode != MODE_STOP);
        scan_byte(it);
        if (typed) begin
            if (cnt > 0)
                owe_span(t_out_item'{span_begin: b0, span_end: e0, run_last: cnt == 1});
            if (cnt > 1)
                owe_span(t_out_item'{span_begin: b1, span_end: e1, run_last: 1'b1});
        end else begin
            for (int k = 0; k < got; k++) owe_span(got_span[k]);
        end
        items_sent++;
        if (was_live) live_items++;
    endtask

    // sender holds off until the dut has delivered every owed span
    task automatic hold_until_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (span_fifo.size() != 0) @(posedge i_clk);
    endtask

    // directed tags; typed spans where they are obvious, predictor elsewhere
    t_row dir_rows [NUM_ROWS] = '{
        // single byte tag, arbitrary first byte, base at the top
        '{8'h00,     32'hFFFF_FFFF, 1'b1, 1'b1, 0, 32'h0, 32'h0, 32'h0, 32'h0},
        // tag across the position wrap: k="<ff>" then empty name, unquoted, cut by slash
        '{CH_LT,     32'hFFFF_FFFE, 1'b0, 1'b0, 0, 32'h0, 32'h0, 32'h0, 32'h0},
        '{8'h65,     32'hFFFF_FFFF, 1'b0, 1'b0, 0, 32'h0, 32'h0, 32'h0, 32'h0},
        '{CH_SPACE,  32'h0000_0000, 1'b0, 1'b0, 0, 32'h0, 32'h0, 32'h0, 32'h0},
        '{8'h6B,     32'h0000_0000, 1'b0, 1'b0, 0, 32'h0, 32'h0, 32'h0, 32'h0},
        '{CH_EQUAL,  32'h0000_0000, 1'b0, 1'b0, 0, 32'h0, 32'h0, 32'h0, 32'h0},
        '{CH_DQUOTE, 32'h0000_0000, 1'b0, 1'b0, 0, 32'h0, 32'h0, 32'h0, 32'h0},
        '{8'hFF,     32'h0000_0000, 1'b0, 1'b0, 0, 32'h0, 32'h0, 32'h0, 32'h0},
        '{CH_DQUOTE, 32'h0000_0000, 1'b0, 1'b1, 1, 32'h1, 32'h6, 32'h0, 32'h0},
        '{CH_SPACE,  32'h0000_0000, 1'b0, 1'b0, 0, 32'h0, 32'h0, 32'h0, 32'h0},
        '{CH_EQUAL,  32'h0000_0000, 1'b0, 1'b0, 0, 32'h0, 32'h0, 32'h0, 32'h0},
        '{8'h78,     32'h0000_0000, 1'b0, 1'b1, 1, 32'h7, 32'h7, 32'h0, 32'h0},
        '{CH_SLASH,  32'h0000_0000, 1'b0, 1'b0, 0, 32'h0, 32'h0, 32'h0, 32'h0},
        '{CH_GT,     32'h0000_0000, 1'b1, 1'b0, 0, 32'h0, 32'h0, 32'h0, 32'h0},
        // bare name then unquoted value ending on the last byte: two spans at once
        '{CH_LT,     32'h0000_0100, 1'b0, 1'b0, 0, 32'h0, 32'h0, 32'h0, 32'h0},
        '{8'h65,     32'hFFFF_FFFF, 1'b0, 1'b0, 0, 32'h0, 32'h0, 32'h0, 32'h0},
        '{CH_TAB,    32'h0000_0000, 1'b0, 1'b0, 0, 32'h0, 32'h0, 32'h0, 32'h0},
        '{8'h61,     32'h0000_0000, 1'b0, 1'b0, 0, 32'h0, 32'h0, 32'h0, 32'h0},
        '{CH_LF,     32'h0000_0000, 1'b0, 1'b0, 0, 32'h0, 32'h0, 32'h0, 32'h0},
        '{CH_EQUAL,  32'h0000_0000, 1'b0, 1'b0, 0, 32'h0, 32'h0, 32'h0, 32'h0},
        '{8'h62,     32'h0000_0000, 1'b1, 1'b1, 2, 32'h103, 32'h104, 32'h106, 32'h107},
        // single quote still open at the tag end
        '{CH_LT,     32'h0000_1000, 1'b0, 1'b0, 0, 32'h0, 32'h0, 32'h0, 32'h0},
        '{CH_CR,     32'h0000_0000, 1'b0, 1'b0, 0, 32'h0, 32'h0, 32'h0, 32'h0},
        '{8'h71,     32'h0000_0000, 1'b0, 1'b0, 0, 32'h0, 32'h0, 32'h0, 32'h0},
        '{CH_EQUAL,  32'h0000_0000, 1'b0, 1'b0, 0, 32'h0, 32'h0, 32'h0, 32'h0},
        '{CH_SQUOTE, 32'h0000_0000, 1'b1, 1'b1, 1, 32'h1002, 32'h1005, 32'h0, 32'h0},
        // stop char in place of the element name
        '{CH_LT,     32'h8000_0000, 1'b0, 1'b0, 0, 32'h0, 32'h0, 32'h0, 32'h0},
        '{CH_GT,     32'h0000_0000, 1'b1, 1'b1, 0, 32'h0, 32'h0, 32'h0, 32'h0}
    };

    // idle percentages per random phase: none, sender, receiver, both
    int phase_send  [NUM_PHASES] = '{0, 57, 0, 20};
    int phase_stall [NUM_PHASES] = '{0, 0, 57, 20};

    initial begin
        t_in_item it;
        int       target;
        // reset held low from the start, released at a falling edge
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        foreach (dir_rows[r]) begin
            it.text_byte = dir_rows[r].c;
            it.tag_base  = dir_rows[r].base;
            it.tag_last  = dir_rows[r].last;
            send_byte(it, dir_rows[r].typed, dir_rows[r].cnt,
                      dir_rows[r].b0, dir_rows[r].e0, dir_rows[r].b1, dir_rows[r].e1);
        end
        hold_until_drained();

        // random part, one phase per idling pattern
        for (int p = 0; p < NUM_PHASES; p++) begin
            send_idle_pct = phase_send[p];
            stall_pct     = phase_stall[p];
            target = live_items + RANDOM_ITEMS / NUM_PHASES;
            while (live_items < target) begin
                build_tag();
                foreach (tag_bytes[k]) send_byte(tag_bytes[k], 1'b0, 0, '0, '0, '0, '0);
                tags_sent++;
                // now and then let the span queue run dry
                if (tags_sent % 40 == 0) hold_until_drained();
            end
        end

        // wind down: all owed spans in, then a quiet wait for strays
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (span_fifo.size() != 0)
            report_mismatch($sformatf("%0d spans never arrived", span_fifo.size()));

        $display("summary: %0d byte transfers (%0d scanned) over %0d random tags plus directed",
                 items_sent, live_items, tags_sent);
        $display("summary: %0d span transfers checked, %0d mismatches", spans_seen, err_count);
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
